[rtl/uwl_pkg.sv]
// ----------------------------------------------------------------------------
// uwl_pkg
// shared constants, codes and types of the utf-8 line wrapper
// ----------------------------------------------------------------------------
package uwl_pkg;

    localparam int BUFFER_BYTES = 8192;
    localparam int POS_W        = $clog2(BUFFER_BYTES + 1);
    localparam logic [POS_W-1:0] BUFFER_LIMIT = POS_W'(BUFFER_BYTES);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int MAX_RESULTS = 3;
    localparam int RIDX_W      = $clog2(MAX_RESULTS);

    localparam int VIEW_W  = 12;
    localparam int WIDE_W  = 8;
    localparam int SUM_W   = 13;
    localparam int LEN_W   = 14;
    localparam int START_W = 32;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [1:0] KIND_HARD    = 2'd0;
    localparam logic [1:0] KIND_WRAP    = 2'd1;
    localparam logic [1:0] KIND_PARTIAL = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    localparam logic [1:0] REG_VIEW_WIDTH  = 2'd0;
    localparam logic [1:0] REG_WIDE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_BASE_OFFSET = 2'd2;

    localparam logic [VIEW_W-1:0]  VIEW_WIDTH_RESET  = 12'd800;
    localparam logic [WIDE_W-1:0]  WIDE_WIDTH_RESET  = 8'd16;
    localparam logic [START_W-1:0] BASE_OFFSET_RESET = 32'd0;

    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] MASK_TOP1  = 8'h80;
    localparam logic [7:0] MASK_TOP2  = 8'hc0;
    localparam logic [7:0] MASK_TOP3  = 8'he0;
    localparam logic [7:0] MASK_TOP4  = 8'hf0;
    localparam logic [7:0] CODE_CONT  = 8'h80;
    localparam logic [7:0] CODE_LEAD2 = 8'hc0;
    localparam logic [7:0] CODE_LEAD3 = 8'he0;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] len;
        logic [1:0]       kind;
    } res_t;

    typedef struct packed {
        logic [RIDX_W-1:0]        count;
        res_t [MAX_RESULTS-1:0]   res;
    } entry_t;

endpackage

[rtl/uwl_if.sv]
// ----------------------------------------------------------------------------
// uwl_if
// valid/ready channels for text bytes and line results
// ----------------------------------------------------------------------------
interface uwl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic [7:0] glyph_width;
    logic       end_of_buffer;

    modport source
    (
        output valid, text_byte, glyph_width, end_of_buffer,
        input  ready
    );
    modport sink
    (
        input  valid, text_byte, glyph_width, end_of_buffer,
        output ready
    );
endinterface

interface uwl_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] line_start;
    logic [13:0] line_length;
    logic [1:0]  line_kind;
    logic        last_of_run;

    modport source
    (
        output valid, line_start, line_length, line_kind, last_of_run,
        input  ready
    );
    modport sink
    (
        input  valid, line_start, line_length, line_kind, last_of_run,
        output ready
    );
endinterface

[rtl/uwl_front.sv]
// ----------------------------------------------------------------------------
// uwl_front
// classifies one byte a cycle while the queue is not full, tracks the open line, packs the results
// ----------------------------------------------------------------------------
module uwl_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    uwl_in_if.sink                     byte_ch,
    input  logic [uwl_pkg::VIEW_W-1:0] view_width,
    input  logic [uwl_pkg::WIDE_W-1:0] wide_width,
    input  logic                       full,
    output logic                       push,
    output uwl_pkg::entry_t            entry
);
    import uwl_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] len_reg, len_next;
    logic [SUM_W-1:0] w_reg, w_next;
    logic             pcr_reg, pcr_next;
    logic [1:0]       cont_reg, cont_next;
    logic             skip_reg, skip_next;

    logic [RIDX_W-1:0] n;
    logic              accept;

    assign byte_ch.ready = !full;
    assign accept        = byte_ch.valid && !full;

    always_comb
    begin
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  len;
        logic [SUM_W-1:0]  w;
        logic [SUM_W:0]    trial;
        logic [WIDE_W-1:0] cw;
        logic [1:0]        extra;
        logic [7:0]        b;
        logic              done;
        logic              last;

        b         = byte_ch.text_byte;
        pos       = pos_reg;
        len       = len_reg;
        w         = w_reg;
        done      = 1'b0;
        pcr_next  = pcr_reg;
        cont_next = cont_reg;
        skip_next = skip_reg;
        cw        = '0;
        extra     = 2'd0;
        trial     = '0;
        n         = '0;
        entry     = '0;

        if (cont_reg != 2'd0)
        begin
            len       = len + 1'b1;
            pos       = pos + 1'b1;
            cont_next = cont_reg - 2'd1;
            done      = 1'b1;
        end
        else if (pcr_reg)
        begin
            pcr_next = 1'b0;
            if (b == CHAR_LF)
            begin
                len  = len + 1'b1;
                pos  = pos + 1'b1;
                done = 1'b1;
            end
            entry.res[n] = '{pos: pos, len: len, kind: KIND_HARD};
            n            = n + 1'b1;
            len          = '0;
            w            = '0;
        end

        if (!done)
        begin
            if (skip_reg && (b & MASK_TOP2) == CODE_CONT)
            begin
                pos = pos + 1'b1;
            end
            else
            begin
                skip_next = 1'b0;
                if (b == CHAR_CR)
                begin
                    len = len + 1'b1;
                    pos = pos + 1'b1;
                    if (byte_ch.end_of_buffer || pos >= BUFFER_LIMIT)
                    begin
                        entry.res[n] = '{pos: pos, len: len, kind: KIND_HARD};
                        n            = n + 1'b1;
                        len          = '0;
                        w            = '0;
                    end
                    else
                    begin
                        pcr_next = 1'b1;
                    end
                end
                else if (b == CHAR_LF)
                begin
                    len          = len + 1'b1;
                    pos          = pos + 1'b1;
                    entry.res[n] = '{pos: pos, len: len, kind: KIND_HARD};
                    n            = n + 1'b1;
                    len          = '0;
                    w            = '0;
                end
                else if ((b & MASK_TOP1) == 8'h00 || (b & MASK_TOP3) == CODE_LEAD2
                         || (b & MASK_TOP4) == CODE_LEAD3)
                begin
                    if ((b & MASK_TOP1) == 8'h00)
                    begin
                        cw    = byte_ch.glyph_width;
                        extra = 2'd0;
                    end
                    else if ((b & MASK_TOP3) == CODE_LEAD2)
                    begin
                        cw    = wide_width;
                        extra = 2'd1;
                    end
                    else
                    begin
                        cw    = wide_width;
                        extra = 2'd2;
                    end
                    trial = {1'b0, w} + {{(SUM_W + 1 - WIDE_W){1'b0}}, cw};
                    if (len != '0 && trial > {{(SUM_W + 1 - VIEW_W){1'b0}}, view_width})
                    begin
                        entry.res[n] = '{pos: pos, len: len, kind: KIND_WRAP};
                        n            = n + 1'b1;
                        len          = '0;
                        w            = '0;
                    end
                    w         = w + {{(SUM_W - WIDE_W){1'b0}}, cw};
                    len       = len + 1'b1;
                    pos       = pos + 1'b1;
                    cont_next = extra;
                end
                else
                begin
                    skip_next = 1'b1;
                    pos       = pos + 1'b1;
                end
            end
        end

        last = byte_ch.end_of_buffer || pos >= BUFFER_LIMIT;
        if (last)
        begin
            if (len != '0)
            begin
                entry.res[n] = '{pos: pos, len: len, kind: KIND_PARTIAL};
            end
            else
            begin
                entry.res[n] = '{pos: pos, len: '0, kind: KIND_END};
            end
            n         = n + 1'b1;
            pos_next  = '0;
            len_next  = '0;
            w_next    = '0;
            pcr_next  = 1'b0;
            cont_next = 2'd0;
            skip_next = 1'b0;
        end
        else
        begin
            pos_next = pos;
            len_next = len;
            w_next   = w;
        end
        entry.count = n;
    end

    assign push = accept && (n != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            len_reg  <= '0;
            w_reg    <= '0;
            pcr_reg  <= 1'b0;
            cont_reg <= 2'd0;
            skip_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            w_reg    <= w_next;
            pcr_reg  <= pcr_next;
            cont_reg <= cont_next;
            skip_reg <= skip_next;
        end
    end

endmodule

[rtl/uwl_queue.sv]
// ----------------------------------------------------------------------------
// uwl_queue
// short fifo of packed result groups between front and back
// ----------------------------------------------------------------------------
module uwl_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  uwl_pkg::entry_t wr_entry,
    output logic            full,
    input  logic            pop,
    output uwl_pkg::entry_t head,
    output logic            empty
);
    import uwl_pkg::*;

    entry_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[rtl/uwl_back.sv]
// ----------------------------------------------------------------------------
// uwl_back
// unpacks result groups one line a cycle, while line_ch is not stalled, into the output register
// ----------------------------------------------------------------------------
module uwl_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  uwl_pkg::entry_t             head,
    input  logic                        empty,
    output logic                        pop,
    input  logic [uwl_pkg::START_W-1:0] base_offset,
    uwl_out_if.source                   line_ch
);
    import uwl_pkg::*;

    logic [RIDX_W-1:0]  idx_reg, idx_next;
    logic               valid_reg, valid_next;
    logic [START_W-1:0] start_reg;
    logic [LEN_W-1:0]   length_reg;
    logic [1:0]         kind_reg;
    logic               last_reg;

    res_t               cur;
    logic               load;
    logic               last;
    logic [POS_W-1:0]   offset;

    assign cur    = head.res[idx_reg];
    assign load   = !empty && (!valid_reg || line_ch.ready);
    assign last   = (idx_reg == head.count - 1'b1);
    assign pop    = load && last;
    assign offset = cur.pos - cur.len;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = last ? '0 : idx_reg + 1'b1;
            valid_next = 1'b1;
        end
        else if (line_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            start_reg  <= base_offset + START_W'(offset);
            length_reg <= LEN_W'(cur.len);
            kind_reg   <= cur.kind;
            last_reg   <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign line_ch.valid       = valid_reg;
    assign line_ch.line_start  = start_reg;
    assign line_ch.line_length = length_reg;
    assign line_ch.line_kind   = kind_reg;
    assign line_ch.last_of_run = last_reg;

endmodule

[rtl/utf8_width_line_wrap_top.sv]
// ----------------------------------------------------------------------------
// utf8_width_line_wrap_top
// greedy utf-8 line wrapper with apb configuration
// ----------------------------------------------------------------------------
// byte_ch takes one text byte per transfer with its glyph width and an end of
// buffer flag; line_ch gives one line per transfer: start offset, length,
// kind and a flag on the last line caused by a byte.
// a byte is taken every cycle while the four-group result queue has room.
// each byte makes zero to three lines; they leave one per cycle, the first
// shown on line_ch after the queue and the output register, so sustained rate is
// one byte a cycle unless the bytes cause more than one line each on average.
// the output register is the only stage on line_ch; when the receiver stalls
// it holds its line, the queue fills and byte_ch.ready drops.
// registers: view width at 0x0, wide width at 0x4, base offset at 0x8;
// write them only while idle.
// reset clears the line state, empties the queue and loads 800, 16 and 0.
// ----------------------------------------------------------------------------
module utf8_width_line_wrap_top
(
    input  logic                       clk,
    input  logic                       rst_n,
    uwl_in_if.sink                     byte_ch,
    uwl_out_if.source                  line_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [uwl_pkg::ADDR_W-1:0] paddr,
    input  logic [uwl_pkg::DATA_W-1:0] pwdata,
    output logic [uwl_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import uwl_pkg::*;

    logic [VIEW_W-1:0]  view_width_reg;
    logic [WIDE_W-1:0]  wide_width_reg;
    logic [START_W-1:0] base_offset_reg;
    logic [1:0]         reg_index;
    logic               wr_en;

    logic   push;
    logic   full;
    logic   pop;
    logic   empty;
    entry_t wr_entry;
    entry_t head;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_width_reg  <= VIEW_WIDTH_RESET;
            wide_width_reg  <= WIDE_WIDTH_RESET;
            base_offset_reg <= BASE_OFFSET_RESET;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_VIEW_WIDTH:  view_width_reg  <= pwdata[VIEW_W-1:0];
                REG_WIDE_WIDTH:  wide_width_reg  <= pwdata[WIDE_W-1:0];
                REG_BASE_OFFSET: base_offset_reg <= pwdata[START_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_VIEW_WIDTH:  prdata = {{(DATA_W - VIEW_W){1'b0}}, view_width_reg};
            REG_WIDE_WIDTH:  prdata = {{(DATA_W - WIDE_W){1'b0}}, wide_width_reg};
            REG_BASE_OFFSET: prdata = base_offset_reg;
            default:         prdata = '0;
        endcase
    end

    uwl_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .view_width (view_width_reg),
        .wide_width (wide_width_reg),
        .full       (full),
        .push       (push),
        .entry      (wr_entry)
    );

    uwl_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    uwl_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .base_offset (base_offset_reg),
        .line_ch     (line_ch)
    );

    a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("result group pushed into a full queue");

    a_end_of_buffer_makes_line : assert property (@(posedge clk) disable iff (!rst_n)
        (byte_ch.valid && byte_ch.ready && byte_ch.end_of_buffer) |-> push)
        else $error("end of buffer without a closing result");

    a_end_marker_empty : assert property (@(posedge clk) disable iff (!rst_n)
        (line_ch.valid && line_ch.line_kind == KIND_END)
            |-> (line_ch.line_length == '0 && line_ch.last_of_run))
        else $error("end marker with a length or not last");

    a_group_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (head.count != '0))
        else $error("queue holds an empty result group");

endmodule
